// ===== design/ncp_pkg.sv =====
// Shared types and constants of the nested call time profiler.
// Used by the interfaces, the stack unit and the top level; depends on nothing.
package ncp_pkg;

	localparam int CMD_W  = 2;
	localparam int ID_W   = 6;
	localparam int TS_W   = 64;
	localparam int CNT_W  = 32;
	localparam int STAT_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_START = 2'd0,
		CMD_STOP  = 2'd1,
		CMD_ENTER = 2'd2,
		CMD_LEAVE = 2'd3
	} cmd_t;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	// One entry of the per-function statistics memory
	typedef struct packed {
		logic             valid;
		logic [CNT_W-1:0] calls;
		logic [TS_W-1:0]  incl;
		logic [TS_W-1:0]  child;
	} tbl_word_t;

	// One call frame below the top of the stack
	typedef struct packed {
		logic [TS_W-1:0] start;
		logic [TS_W-1:0] child;
	} stk_frame_t;

	// Update of the call stack, applied when an event commits
	typedef struct packed {
		logic            clear;
		logic            push;
		logic            pop;
		logic [TS_W-1:0] ts;
		logic [TS_W-1:0] delta;
	} stk_op_t;

	// Call stack fill status
	typedef struct packed {
		logic empty;
		logic full;
		logic single;
	} stk_stat_t;

endpackage

// ===== design/ncp_evt_if.sv =====
// Event channel of the profiler: valid/ready handshake with the event fields.
// Depends on ncp_pkg.
interface ncp_evt_if;
	import ncp_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [ID_W-1:0]   function_id;
	logic [TS_W-1:0]   timestamp;

	modport source(output valid, output cmd, output function_id, output timestamp,
		input ready);
	modport sink(input valid, input cmd, input function_id, input timestamp,
		output ready);
endinterface

// ===== design/ncp_res_if.sv =====
// Result channel of the profiler: valid/ready handshake with the result fields.
// Depends on ncp_pkg.
interface ncp_res_if;
	import ncp_pkg::*;

	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic              is_active;
	logic [CNT_W-1:0]  entry_calls;
	logic [TS_W-1:0]   entry_inclusive_time;
	logic [TS_W-1:0]   entry_child_time;
	logic [TS_W-1:0]   grand_total;
	logic [CNT_W-1:0]  timing_errors;
	logic [TS_W-1:0]   session_time;

	modport source(output valid, output status, output is_active, output entry_calls,
		output entry_inclusive_time, output entry_child_time, output grand_total,
		output timing_errors, output session_time, input ready);
	modport sink(input valid, input status, input is_active, input entry_calls,
		input entry_inclusive_time, input entry_child_time, input grand_total,
		input timing_errors, input session_time, output ready);
endinterface

// ===== design/ncp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ncp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and read one word a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== design/ncp_stack.sv =====
// Call stack of the profiler: top frame in registers, lower frames in a RAM.
// Depends on ncp_pkg and ncp_ram.
module ncp_stack #(
	parameter int STACK_DEPTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    rd_en,
	input  ncp_pkg::stk_op_t        op,
	output ncp_pkg::stk_stat_t      stat,
	output logic [ncp_pkg::TS_W-1:0] top_start,
	output logic [ncp_pkg::TS_W-1:0] top_child
);
	import ncp_pkg::*;

	localparam int SW = $clog2(STACK_DEPTH);
	localparam int LW = $clog2(STACK_DEPTH + 1);

	logic [LW-1:0]   level_q;
	logic [TS_W-1:0] top_start_q;
	logic [TS_W-1:0] top_child_q;
	logic [SW-1:0]   waddr;
	logic [SW-1:0]   raddr;
	logic            we;
	stk_frame_t      wr_frame;
	stk_frame_t      rd_frame;

	// Spill the top frame on push; prefetch the parent frame at event accept
	assign waddr    = SW'(level_q - LW'(1));
	assign raddr    = SW'(level_q - LW'(2));
	assign we       = op.push && (level_q != '0);
	assign wr_frame = '{start: top_start_q, child: top_child_q};

	ncp_ram #(
		.WIDTH($bits(stk_frame_t)),
		.DEPTH(STACK_DEPTH)
	) u_frames (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wr_frame),
		.re   (rd_en),
		.raddr(raddr),
		.rdata(rd_frame)
	);

	assign stat.empty  = (level_q == '0);
	assign stat.full   = (level_q >= LW'(STACK_DEPTH));
	assign stat.single = (level_q == LW'(1));

	// Track the frame count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (op.clear) begin
			level_q <= '0;
		end else if (op.push) begin
			level_q <= level_q + LW'(1);
		end else if (op.pop) begin
			level_q <= level_q - LW'(1);
		end
	end

	// Load a fresh frame on push; on pop promote the parent and charge it the callee time
	always_ff @(posedge clk) begin
		if (op.push) begin
			top_start_q <= op.ts;
			top_child_q <= '0;
		end else if (op.pop && (level_q >= LW'(2))) begin
			top_start_q <= rd_frame.start;
			top_child_q <= rd_frame.child + op.delta;
		end
	end

	assign top_start = top_start_q;
	assign top_child = top_child_q;
endmodule

// ===== design/nested_call_time_profiler.sv =====
// Nested call time profiler, top level. Depends on ncp_pkg, the two channel
// interfaces, ncp_stack and ncp_ram.
// The event is registered at accept, and the result beat is registered when the event commits.
// Events do not overlap: a new event is accepted only after the last one commits, as the statistics
// RAM entry is read at accept and written back at commit; a held result beat stalls the commit.
// Reset: control clears asynchronously; a pass clearing every statistics RAM entry runs here and after start.
module nested_call_time_profiler #(
	parameter int STACK_DEPTH = 16,
	parameter int FUNC_COUNT  = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	ncp_evt_if.sink  evt,
	ncp_res_if.source res
);
	import ncp_pkg::*;

	localparam int FW  = $clog2(FUNC_COUNT);
	localparam int IXW = (FW > ID_W) ? FW : ID_W;

	state_t            state_q;
	state_t            state_d;
	logic              evt_ready;
	logic              accept;
	logic              commit;
	logic [FW-1:0]     clr_addr_q;

	// Event registered at accept
	cmd_t              cmd_s1;
	logic [ID_W-1:0]   id_s1;
	logic              id_ok_s1;
	logic [TS_W-1:0]   ts_s1;
	logic [TS_W-1:0]   delta_s1;
	logic              neg_s1;
	logic [TS_W-1:0]   sess_diff_s1;

	// Profiler state
	logic              active_q;
	logic [TS_W-1:0]   top_total_q;
	logic [CNT_W-1:0]  err_q;
	logic [TS_W-1:0]   sess_start_q;
	logic [TS_W-1:0]   sess_stop_q;

	// Result register
	logic              res_valid_q;
	logic [STAT_W-1:0] res_status_q;
	logic              res_active_q;
	tbl_word_t         res_entry_q;
	logic [TS_W-1:0]   res_total_q;
	logic [CNT_W-1:0]  res_err_q;
	logic [TS_W-1:0]   res_sess_q;

	// Combinational
	cmd_t              evt_cmd;
	logic [IXW-1:0]    id_wide_in;
	logic [IXW-1:0]    id_wide_s1;
	logic [TS_W-1:0]   raw_delta;
	logic [TS_W-1:0]   stop_v;
	logic [TS_W-1:0]   start_v;
	logic              evt_id_ok;
	tbl_word_t         tbl_rd;
	tbl_word_t         tbl_base;
	tbl_word_t         tbl_upd;
	tbl_word_t         tbl_wdata;
	tbl_word_t         entry_c;
	logic              tbl_we;
	logic [FW-1:0]     tbl_waddr;
	logic              do_push;
	logic              do_pop;
	logic [STAT_W-1:0] status_c;
	logic [CNT_W-1:0]  err_next;
	logic [TS_W-1:0]   total_next;
	logic              active_next;
	stk_op_t           stk_op;
	stk_stat_t         stk_stat;
	logic [TS_W-1:0]   stk_top_start;
	logic [TS_W-1:0]   stk_top_child;

	// Sequencer: clearing pass, wait for an event, commit it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		evt_ready = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == FW'(FUNC_COUNT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				evt_ready = 1'b1;
				if (evt.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!res_valid_q || res.ready) begin
					commit  = 1'b1;
					state_d = (cmd_s1 == CMD_START) ? ST_CLEAR : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	assign evt.ready = evt_ready;
	assign accept    = evt.valid && evt_ready;

	// Step the clearing address through the statistics RAM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_addr_q <= (clr_addr_q == FW'(FUNC_COUNT - 1)) ? '0 : clr_addr_q + FW'(1);
		end
	end

	// Precompute elapsed time and session length at accept
	assign evt_cmd    = cmd_t'(evt.cmd);
	assign id_wide_in = IXW'(evt.function_id);
	assign evt_id_ok  = 32'(evt.function_id) < 32'(FUNC_COUNT);
	assign raw_delta  = evt.timestamp - stk_top_start;
	assign stop_v     = (evt_cmd == CMD_STOP) ? evt.timestamp : sess_stop_q;
	assign start_v    = (evt_cmd == CMD_START) ? evt.timestamp : sess_start_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1       <= evt_cmd;
			id_s1        <= evt.function_id;
			id_ok_s1     <= evt_id_ok;
			ts_s1        <= evt.timestamp;
			neg_s1       <= raw_delta[TS_W-1];
			delta_s1     <= raw_delta[TS_W-1] ? '0 : raw_delta;
			sess_diff_s1 <= stop_v - start_v;
		end
	end

	// Statistics RAM: read at accept, write back at commit or clear
	assign id_wide_s1 = IXW'(id_s1);
	assign tbl_we     = (state_q == ST_CLEAR) || (do_pop && id_ok_s1);
	assign tbl_waddr  = (state_q == ST_CLEAR) ? clr_addr_q : id_wide_s1[FW-1:0];
	assign tbl_wdata  = (state_q == ST_CLEAR) ? '0 : tbl_upd;

	ncp_ram #(
		.WIDTH($bits(tbl_word_t)),
		.DEPTH(FUNC_COUNT)
	) u_stats (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(tbl_waddr),
		.wdata(tbl_wdata),
		.re   (accept),
		.raddr(id_wide_in[FW-1:0]),
		.rdata(tbl_rd)
	);

	ncp_stack #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.op       (stk_op),
		.stat     (stk_stat),
		.top_start(stk_top_start),
		.top_child(stk_top_child)
	);

	// Decide the event's effect
	assign do_push = commit && (cmd_s1 == CMD_ENTER) && active_q && !stk_stat.full;
	assign do_pop  = commit && (cmd_s1 == CMD_LEAVE) && active_q && !stk_stat.empty;

	assign stk_op.clear = commit && (cmd_s1 == CMD_START);
	assign stk_op.push  = do_push;
	assign stk_op.pop   = do_pop;
	assign stk_op.ts    = ts_s1;
	assign stk_op.delta = delta_s1;

	always_comb begin
		status_c = STAT_OK;
		if (active_q && (cmd_s1 == CMD_ENTER) && stk_stat.full) begin
			status_c = STAT_FULL;
		end else if (active_q && (cmd_s1 == CMD_LEAVE) && stk_stat.empty) begin
			status_c = STAT_EMPTY;
		end
	end

	// Fold the finished call into its entry; an invalid entry starts from zero
	always_comb begin
		tbl_base      = tbl_rd.valid ? tbl_rd : '0;
		tbl_upd.valid = 1'b1;
		tbl_upd.calls = (tbl_base.calls == '1) ? tbl_base.calls : tbl_base.calls + CNT_W'(1);
		tbl_upd.incl  = tbl_base.incl + delta_s1;
		tbl_upd.child = tbl_base.child + stk_top_child;
	end

	always_comb begin
		if (do_pop && id_ok_s1) begin
			entry_c = tbl_upd;
		end else if (cmd_s1 == CMD_START) begin
			entry_c = '0;
		end else if (id_ok_s1 && tbl_rd.valid) begin
			entry_c = tbl_rd;
		end else begin
			entry_c = '0;
		end
	end

	// Next values of the global counters
	always_comb begin
		err_next    = err_q;
		total_next  = top_total_q;
		active_next = active_q;
		unique case (cmd_s1)
			CMD_START: begin
				err_next    = '0;
				total_next  = '0;
				active_next = 1'b1;
			end
			CMD_STOP: begin
				active_next = 1'b0;
			end
			CMD_ENTER: begin
				active_next = active_q;
			end
			CMD_LEAVE: begin
				if (do_pop && neg_s1 && (err_q != '1)) begin
					err_next = err_q + CNT_W'(1);
				end
				if (do_pop && stk_stat.single) begin
					total_next = top_total_q + delta_s1;
				end
			end
			default: begin
				active_next = active_q;
			end
		endcase
	end

	// Commit the profiler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			top_total_q  <= '0;
			err_q        <= '0;
			sess_start_q <= '0;
			sess_stop_q  <= '0;
		end else if (commit) begin
			active_q    <= active_next;
			top_total_q <= total_next;
			err_q       <= err_next;
			if (cmd_s1 == CMD_START) begin
				sess_start_q <= ts_s1;
			end
			if (cmd_s1 == CMD_STOP) begin
				sess_stop_q <= ts_s1;
			end
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (commit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_status_q <= status_c;
			res_active_q <= active_next;
			res_entry_q  <= entry_c;
			res_total_q  <= total_next;
			res_err_q    <= err_next;
			res_sess_q   <= sess_diff_s1;
		end
	end

	assign res.valid                = res_valid_q;
	assign res.status               = res_status_q;
	assign res.is_active            = res_active_q;
	assign res.entry_calls          = res_entry_q.calls;
	assign res.entry_inclusive_time = res_entry_q.incl;
	assign res.entry_child_time     = res_entry_q.child;
	assign res.grand_total          = res_total_q;
	assign res.timing_errors        = res_err_q;
	assign res.session_time         = res_sess_q;

	// A committed event always presents its result in the next cycle
	a_commit_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> res.valid)
		else $error("committed event produced no result beat");

	// A start shows an active session with cleared statistics
	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (cmd_s1 == CMD_START) |=>
			res.is_active && (res.entry_calls == '0) && (res.grand_total == '0)
			&& (res.timing_errors == '0))
		else $error("start did not clear the statistics");

	// A rejected push leaves the stack full and reports it
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (cmd_s1 == CMD_ENTER) && active_q && stk_stat.full |=>
			stk_stat.full && (res.status == STAT_FULL))
		else $error("enter on a full stack changed the stack");
endmodule

// ===== test/tb_nested_call_time_profiler.sv =====
`timescale 1ns / 100ps
// Testbench for nested_call_time_profiler: random and directed event streams, with a scoreboard
// that predicts every result. Depends on ncp_pkg, ncp_evt_if, ncp_res_if and the block itself.
module tb_nested_call_time_profiler;
	import ncp_pkg::*;

	localparam int DEPTH_N      = 16;
	localparam int FUNC_N       = 64;
	localparam int RAND_ITEMS   = 600;
	localparam int QUIET_ITEMS  = 100;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              is_active;
		logic [CNT_W-1:0]  entry_calls;
		logic [TS_W-1:0]   entry_inclusive_time;
		logic [TS_W-1:0]   entry_child_time;
		logic [TS_W-1:0]   grand_total;
		logic [CNT_W-1:0]  timing_errors;
		logic [TS_W-1:0]   session_time;
	} prof_result_t;

	// Shadow copy of the profiler state and the queue of results it predicts
	class profile_scoreboard;
		logic [TS_W-1:0]  frame_start [DEPTH_N];
		logic [TS_W-1:0]  frame_child [DEPTH_N];
		int unsigned      level;
		logic [CNT_W-1:0] call_tbl [FUNC_N];
		logic [TS_W-1:0]  incl_tbl [FUNC_N];
		logic [TS_W-1:0]  child_tbl [FUNC_N];
		bit               entry_seen [FUNC_N];
		logic [TS_W-1:0]  top_sum;
		logic [CNT_W-1:0] clamp_cnt;
		bit               active;
		logic [TS_W-1:0]  sess_start;
		logic [TS_W-1:0]  sess_stop;
		prof_result_t     expected_q[$];
		int               fail_count;
		int               result_idx;

		function new();
			level = 0;
			top_sum = '0;
			clamp_cnt = '0;
			active = 1'b0;
			sess_start = '0;
			sess_stop = '0;
			fail_count = 0;
			result_idx = 0;
			foreach (entry_seen[i]) entry_seen[i] = 1'b0;
		endfunction

		// Apply one accepted event beat and queue the result it must produce
		function void note_event(cmd_t c, logic [ID_W-1:0] id, logic [TS_W-1:0] ts);
			prof_result_t r;
			logic [TS_W-1:0] delta;
			logic [TS_W-1:0] below;
			r = '0;
			r.status = STAT_OK;
			case (c)
				CMD_START: begin
					foreach (entry_seen[i]) entry_seen[i] = 1'b0;
					level = 0;
					top_sum = '0;
					clamp_cnt = '0;
					active = 1'b1;
					sess_start = ts;
				end
				CMD_STOP: begin
					sess_stop = ts;
					active = 1'b0;
				end
				CMD_ENTER: if (active) begin
					if (level >= DEPTH_N) begin
						r.status = STAT_FULL;
					end else begin
						frame_start[level] = ts;
						frame_child[level] = '0;
						level++;
					end
				end
				CMD_LEAVE: if (active) begin
					if (level == 0) begin
						r.status = STAT_EMPTY;
					end else begin
						level--;
						delta = ts - frame_start[level];
						below = frame_child[level];
						// clamp a backward step and count it
						if (delta[TS_W-1]) begin
							delta = '0;
							if (clamp_cnt != '1) clamp_cnt++;
						end
						if (!entry_seen[id]) begin
							call_tbl[id] = '0;
							incl_tbl[id] = '0;
							child_tbl[id] = '0;
							entry_seen[id] = 1'b1;
						end
						if (call_tbl[id] != '1) call_tbl[id]++;
						incl_tbl[id] += delta;
						child_tbl[id] += below;
						// hand the elapsed time to the caller, or to the total at top level
						if (level > 0) frame_child[level-1] += delta;
						else top_sum += delta;
					end
				end
			endcase
			r.is_active = active;
			if (entry_seen[id]) begin
				r.entry_calls = call_tbl[id];
				r.entry_inclusive_time = incl_tbl[id];
				r.entry_child_time = child_tbl[id];
			end
			r.grand_total = top_sum;
			r.timing_errors = clamp_cnt;
			r.session_time = sess_stop - sess_start;
			expected_q.insert(expected_q.size(), r);
		endfunction

		// Compare one accepted result beat with the oldest prediction
		function void check_result(prof_result_t got);
			prof_result_t want;
			string bad;
			result_idx++;
			if (expected_q.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("result %0d arrived with nothing expected", result_idx);
				return;
			end
			want = expected_q.pop_front();
			bad = "";
			if (got.status !== want.status) bad = {bad, " status"};
			if (got.is_active !== want.is_active) bad = {bad, " is_active"};
			if (got.entry_calls !== want.entry_calls) bad = {bad, " entry_calls"};
			if (got.entry_inclusive_time !== want.entry_inclusive_time)
				bad = {bad, " entry_inclusive_time"};
			if (got.entry_child_time !== want.entry_child_time) bad = {bad, " entry_child_time"};
			if (got.grand_total !== want.grand_total) bad = {bad, " grand_total"};
			if (got.timing_errors !== want.timing_errors) bad = {bad, " timing_errors"};
			if (got.session_time !== want.session_time) bad = {bad, " session_time"};
			if (bad != "") begin
				fail_count++;
				if (fail_count <= REPORT_MAX) begin
					$display("result %0d mismatch in%s", result_idx, bad);
					$display("  expected: st=%0d act=%0d calls=%0d incl=%h child=%h tot=%h err=%0d ses=%h",
						want.status, want.is_active, want.entry_calls, want.entry_inclusive_time,
						want.entry_child_time, want.grand_total, want.timing_errors, want.session_time);
					$display("  actual:   st=%0d act=%0d calls=%0d incl=%h child=%h tot=%h err=%0d ses=%h",
						got.status, got.is_active, got.entry_calls, got.entry_inclusive_time,
						got.entry_child_time, got.grand_total, got.timing_errors, got.session_time);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	ncp_evt_if evt();
	ncp_res_if res();

	nested_call_time_profiler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt),
		.res    (res)
	);

	profile_scoreboard sb;
	bit                quiet = 1'b0;
	bit                gen_active = 1'b0;
	int unsigned       sent_cnt = 0;
	int unsigned       quiet_mark = 32'hFFFF_FFFF;
	int unsigned       cycle_cnt = 0;
	logic [TS_W-1:0]   now_ts;
	logic [ID_W-1:0]   open_ids[$];

	// Free-running clock, 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Drive one event beat, with an optional idle burst ahead of it, and wait for accept
	task automatic send_event(cmd_t c, logic [ID_W-1:0] id, logic [TS_W-1:0] ts);
		int gap;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 4);
			evt.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt.valid <= 1'b1;
		evt.cmd <= c;
		evt.function_id <= id;
		evt.timestamp <= ts;
		@(posedge clk);
		while (!evt.ready) @(posedge clk);
		sb.note_event(c, id, ts);
		// events dropped while the session is off do not count toward the stream length
		if (c == CMD_START || c == CMD_STOP || gen_active) sent_cnt++;
		if (c == CMD_START) gen_active = 1'b1;
		if (c == CMD_STOP) gen_active = 1'b0;
		quiet = (sent_cnt >= quiet_mark);
	endtask

	// Extremes and the special cases, in a fixed order
	task automatic run_directed();
		int i;
		send_event(CMD_LEAVE, 6'd0, '0);
		send_event(CMD_ENTER, 6'd63, '1);
		send_event(CMD_STOP, 6'd21, 64'd100);
		// start at the top of the counter so the next enter wraps
		send_event(CMD_START, 6'd42, '1);
		send_event(CMD_LEAVE, 6'd5, '0);
		send_event(CMD_ENTER, 6'd63, '0);
		// leave stamped earlier than its enter: clamped to zero
		send_event(CMD_LEAVE, 6'd63, '1);
		for (i = 0; i < DEPTH_N; i++)
			send_event(CMD_ENTER, ID_W'(i * 4 + 3), 64'd2000 + i);
		send_event(CMD_ENTER, 6'd0, 64'd3000);
		send_event(CMD_LEAVE, 6'd63, 64'd3100);
		send_event(CMD_STOP, 6'd0, 64'h8000_0000_0000_0000);
	endtask

	// One session: start, a mostly well-nested call sequence, then usually a stop
	task automatic run_session();
		int              n;
		int              k;
		bit              deep;
		bit              go_in;
		logic [ID_W-1:0] pool [4];
		logic [ID_W-1:0] id;
		logic [TS_W-1:0] ts;
		foreach (pool[j]) pool[j] = ID_W'($urandom);
		n = $urandom_range(8, 60);
		deep = ($urandom_range(0, 3) == 0);
		now_ts = {$urandom, $urandom};
		open_ids.delete();
		send_event(CMD_START, ID_W'($urandom), now_ts);
		for (k = 0; k < n; k++) begin
			// pick direction: mostly balanced, sometimes pushing into a full stack or past empty
			if (open_ids.size() == 0) go_in = ($urandom_range(0, 9) != 0);
			else if (open_ids.size() >= DEPTH_N) go_in = ($urandom_range(0, 3) == 0);
			else go_in = ($urandom_range(0, 99) < (deep ? 80 : 50));
			if ($urandom_range(0, 19) == 0) now_ts += $urandom;
			else now_ts += $urandom_range(0, 40);
			ts = now_ts;
			// stray stamp, may run backward
			if ($urandom_range(0, 24) == 0) ts = {$urandom, $urandom};
			id = pool[$urandom_range(0, 3)];
			if ($urandom_range(0, 9) == 0) id = ID_W'($urandom);
			if (go_in) begin
				send_event(CMD_ENTER, id, ts);
				if (open_ids.size() < DEPTH_N) open_ids.insert(open_ids.size(), id);
			end else begin
				if (open_ids.size() > 0 && $urandom_range(0, 9) != 0) id = open_ids[$];
				send_event(CMD_LEAVE, id, ts);
				if (open_ids.size() > 0) open_ids.delete(open_ids.size() - 1);
			end
		end
		// usually close the session, sometimes restart over it
		if ($urandom_range(0, 3) != 0) begin
			send_event(CMD_STOP, ID_W'($urandom), now_ts + $urandom_range(0, 40));
			if ($urandom_range(0, 2) == 0)
				send_event($urandom_range(0, 1) ? CMD_ENTER : CMD_LEAVE, ID_W'($urandom),
					{$urandom, $urandom});
		end
	endtask

	// Result side: check each beat, stall ready in random bursts
	initial begin : rx_side
		int           stall;
		prof_result_t got;
		stall = 0;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res.valid && res.ready) begin
				got.status = res.status;
				got.is_active = res.is_active;
				got.entry_calls = res.entry_calls;
				got.entry_inclusive_time = res.entry_inclusive_time;
				got.entry_child_time = res.entry_child_time;
				got.grand_total = res.grand_total;
				got.timing_errors = res.timing_errors;
				got.session_time = res.session_time;
				sb.check_result(got);
			end
			if (stall > 0) begin
				stall--;
				res.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(0, 3);
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// Stimulus and end of run
	initial begin : main_flow
		int unsigned rand_base;
		sb = new();
		arst_n <= 1'b0;
		evt.valid <= 1'b0;
		evt.cmd <= CMD_START;
		evt.function_id <= '0;
		evt.timestamp <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		rand_base = sent_cnt;
		quiet_mark = rand_base + RAND_ITEMS - QUIET_ITEMS;
		while (sent_cnt < rand_base + RAND_ITEMS) run_session();
		evt.valid <= 1'b0;
		// drain outstanding results, then give the block time to show any extras
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fail_count == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule
